### rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive while reset is asserted
`define CHS_ASSERT_IMP(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, inactive while reset is asserted
`define CHS_ASSERT_NXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/chs_pkg.sv
`default_nettype none
package chs_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ELEM_W       = 32;
    localparam int KIND_W       = 2;
    localparam int COUNT_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int HOME_STEPS   = ELEM_W / DIGIT_W;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HOME,
        OP_WSTART,
        OP_ADV,
        OP_ADD_HOME,
        OP_ADD_FF,
        OP_FFSCAN,
        OP_MV_BEGIN,
        OP_MV_ADV,
        OP_MOVE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
        logic res_ok;
        logic res_full;
    } t_cmd;

    typedef struct packed {
        logic home_last;
        logic home_vld;
        logic home_is_ff;
        logic cnt_full;
        logic ff_full;
        logic ff_stop;
        logic found;
        logic lnk_none;
        logic home_match;
        logic step_cap;
        logic step_cap1;
        logic round_last;
    } t_sts;

endpackage
`default_nettype wire

### rtl/chs_datapath.sv
`default_nettype none
module chs_datapath #(
    parameter int CAPACITY = chs_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [chs_pkg::ELEM_W-1:0]   i_elem,
    input  chs_pkg::t_cmd                i_cmd,
    output chs_pkg::t_sts                o_sts,
    output logic                         o_ok,
    output logic                         o_full,
    output logic [chs_pkg::COUNT_W-1:0]  o_count
);
    import chs_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = IW + 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int DW = $clog2(HOME_STEPS);
    localparam logic [LW-1:0] NONE  = LW'(CAPACITY);
    localparam logic [RW-1:0] CAP_R = RW'(CAPACITY);
    localparam logic [ELEM_W-1:0] E_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [ELEM_W-1:0] E_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

    // slot storage
    logic [ELEM_W-1:0] r_val_mem [CAPACITY];
    logic [IW-1:0]     r_hom_mem [CAPACITY];
    logic [LW-1:0]     r_lnk_mem [CAPACITY];
    logic [CAPACITY-1:0] r_vld;
    logic [CAPACITY-1:0] r_lv;   // link written since slot became occupied

    logic [ELEM_W-1:0] r_v, r_mag, r_rd_val;
    logic [IW-1:0]     r_rem, r_rd_hom;
    logic [LW-1:0]     r_rd_lnk;
    logic [DW-1:0]     r_dig;
    logic [LW-1:0]     r_p, r_i, r_prev, r_pred, r_ilnk, r_step, r_round, r_ff, r_cnt;
    logic              r_ook, r_ofull;
    logic [COUNT_W-1:0] r_ocnt;

    logic [IW-1:0]     p_idx, ff_idx, i_idx, prev_idx;
    logic              p_vld, ff_in;
    logic [LW-1:0]     lnk_p, home_lx;
    logic [ELEM_W-1:0] mag;
    logic [IW-1:0]     n_rem;
    logic [RW-1:0]     rem_t;

    assign p_idx    = r_p[IW-1:0];
    assign ff_idx   = r_ff[IW-1:0];
    assign i_idx    = r_i[IW-1:0];
    assign prev_idx = r_prev[IW-1:0];
    assign p_vld    = (r_p < NONE) && r_vld[p_idx];
    assign ff_in    = r_ff < NONE;
    assign lnk_p    = (p_vld && r_lv[p_idx] && (r_rd_lnk < NONE)) ? r_rd_lnk : NONE;
    assign home_lx  = LW'(r_rem);

    // saturating magnitude
    assign mag = i_elem[ELEM_W-1] ? ((i_elem == E_MIN) ? E_MAX : (~i_elem + 1'b1)) : i_elem;

    // one digit of the magnitude per cycle, msb first, folded into the remainder
    always_comb begin
        rem_t = {1'b0, r_rem};
        for (int k = 0; k < DIGIT_W; k++) begin
            rem_t = {rem_t[IW-1:0], r_mag[ELEM_W-1-k]};
            if (rem_t >= CAP_R) begin
                rem_t = rem_t - CAP_R;
            end
        end
        n_rem = rem_t[IW-1:0];
    end

    always_comb begin
        o_sts.home_last  = r_dig == DW'(HOME_STEPS - 1);
        o_sts.home_vld   = r_vld[r_rem];
        o_sts.home_is_ff = home_lx == r_ff;
        o_sts.cnt_full   = r_cnt >= NONE;
        o_sts.ff_full    = !ff_in;
        o_sts.ff_stop    = !ff_in || !r_vld[ff_idx];
        o_sts.found      = p_vld && (r_rd_val == r_v);
        o_sts.lnk_none   = lnk_p == NONE;
        o_sts.home_match = p_vld && (LW'(r_rd_hom) == r_i);
        o_sts.step_cap   = r_step == NONE;
        o_sts.step_cap1  = (r_step + LW'(1)) == NONE;
        o_sts.round_last = (r_round + LW'(1)) == NONE;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_rd_val <= r_val_mem[p_idx];
        r_rd_hom <= r_hom_mem[p_idx];
        r_rd_lnk <= r_lnk_mem[p_idx];
        unique case (i_cmd.op)
            OP_ADD_HOME: begin
                r_val_mem[r_rem] <= r_v;
                r_hom_mem[r_rem] <= r_rem;
            end
            OP_ADD_FF: begin
                r_val_mem[ff_idx] <= r_v;
                r_hom_mem[ff_idx] <= r_rem;
                r_lnk_mem[p_idx]  <= r_ff;
            end
            OP_MOVE: begin
                r_val_mem[i_idx] <= r_rd_val;
                r_hom_mem[i_idx] <= r_rd_hom;
            end
            OP_FINISH: begin
                if (r_prev != NONE) begin
                    r_lnk_mem[prev_idx] <= r_ilnk;
                end
            end
            default: begin
            end
        endcase
    end

    // walk registers and output payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_v   <= i_elem;
                r_mag <= mag;
                r_rem <= '0;
                r_dig <= '0;
            end
            OP_HOME: begin
                r_mag <= r_mag << DIGIT_W;
                r_rem <= n_rem;
                r_dig <= r_dig + DW'(1);
            end
            OP_WSTART: begin
                r_p    <= home_lx;
                r_step <= '0;
                r_prev <= NONE;
            end
            OP_ADV: begin
                r_prev <= r_p;
                r_p    <= lnk_p;
                r_step <= r_step + LW'(1);
            end
            OP_MV_BEGIN: begin
                r_i     <= r_p;
                r_ilnk  <= lnk_p;
                r_pred  <= r_p;
                r_p     <= lnk_p;
                r_step  <= '0;
                r_round <= '0;
            end
            OP_MV_ADV: begin
                r_pred <= r_p;
                r_p    <= lnk_p;
                r_step <= r_step + LW'(1);
            end
            OP_MOVE: begin
                r_prev  <= r_pred;
                r_i     <= r_p;
                r_ilnk  <= lnk_p;
                r_pred  <= r_p;
                r_p     <= lnk_p;
                r_step  <= '0;
                r_round <= r_round + LW'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_ook   <= i_cmd.res_ok;
            r_ofull <= i_cmd.res_full;
            r_ocnt  <= COUNT_W'(r_cnt);
        end
    end

    // occupancy, free pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_lv  <= '0;
            r_ff  <= '0;
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_ADD_HOME: begin
                    r_vld[r_rem] <= 1'b1;
                    r_lv[r_rem]  <= 1'b0;
                    r_cnt        <= r_cnt + LW'(1);
                end
                OP_ADD_FF: begin
                    r_vld[ff_idx] <= 1'b1;
                    r_lv[ff_idx]  <= 1'b0;
                    r_lv[p_idx]   <= 1'b1;
                    r_ff          <= r_ff + LW'(1);
                    r_cnt         <= r_cnt + LW'(1);
                end
                OP_FFSCAN: begin
                    r_ff <= r_ff + LW'(1);
                end
                OP_FINISH: begin
                    if (r_prev != NONE) begin
                        r_lv[prev_idx] <= 1'b1;
                    end
                    r_vld[i_idx] <= 1'b0;
                    if (r_i < r_ff) begin
                        r_ff <= r_i;
                    end
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - LW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ok    = r_ook;
    assign o_full  = r_ofull;
    assign o_count = r_ocnt;

endmodule
`default_nettype wire

### rtl/chs_ctrl.sv
`default_nettype none
module chs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [chs_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  chs_pkg::t_sts               i_sts,
    output chs_pkg::t_cmd               o_cmd
);
    import chs_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HOME    = 4'd1;
    localparam logic [3:0] S_START   = 4'd2;
    localparam logic [3:0] S_ADDHOME = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_RD      = 4'd5;
    localparam logic [3:0] S_CK      = 4'd6;
    localparam logic [3:0] S_ADDFF   = 4'd7;
    localparam logic [3:0] S_MVB     = 4'd8;
    localparam logic [3:0] S_MRD     = 4'd9;
    localparam logic [3:0] S_MCK     = 4'd10;
    localparam logic [3:0] S_MOVE    = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [KIND_W-1:0] r_kind;
    logic              r_ok, n_ok, r_full, n_full, r_ovalid;
    logic              is_op;

    assign is_op = (r_kind == KIND_ADD) || (r_kind == KIND_REMOVE) || (r_kind == KIND_SEARCH);

    always_comb begin
        n_state        = r_state;
        n_ok           = r_ok;
        n_full         = r_full;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_cmd.res_ok   = r_ok;
        o_cmd.res_full = r_full;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_ok     = 1'b0;
                    n_full   = 1'b0;
                    n_state  = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.op = OP_HOME;
                if (i_sts.home_last) begin
                    n_state = is_op ? S_START : S_DONE;
                end
            end
            S_START: begin
                o_cmd.op = OP_WSTART;
                if (r_kind == KIND_ADD && i_sts.cnt_full) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else if (r_kind == KIND_ADD && !i_sts.home_vld) begin
                    n_state = S_ADDHOME;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ADDHOME: begin
                o_cmd.op = OP_ADD_HOME;
                n_ok     = 1'b1;
                n_state  = i_sts.home_is_ff ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (i_sts.ff_stop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_FFSCAN;
                end
            end
            S_RD: begin
                n_state = S_CK;
            end
            S_CK: begin
                if (r_kind == KIND_REMOVE) begin
                    if (i_sts.found) begin
                        n_state = S_MVB;
                    end else if (i_sts.lnk_none || i_sts.step_cap) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.op = OP_ADV;
                        n_state  = S_RD;
                    end
                end else if (i_sts.found) begin
                    n_ok    = (r_kind == KIND_SEARCH);
                    n_state = S_DONE;
                end else if (i_sts.lnk_none || i_sts.step_cap1) begin
                    n_state = (r_kind == KIND_ADD) ? S_ADDFF : S_DONE;
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state  = S_RD;
                end
            end
            S_ADDFF: begin
                if (i_sts.ff_full) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_ADD_FF;
                    n_ok     = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_MVB: begin
                o_cmd.op = OP_MV_BEGIN;
                n_state  = i_sts.lnk_none ? S_FIN : S_MRD;
            end
            S_MRD: begin
                n_state = S_MCK;
            end
            S_MCK: begin
                if (i_sts.home_match) begin
                    n_state = S_MOVE;
                end else if (i_sts.lnk_none || i_sts.step_cap) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_MV_ADV;
                    n_state  = S_MRD;
                end
            end
            S_MOVE: begin
                o_cmd.op = OP_MOVE;
                n_state  = (i_sts.round_last || i_sts.lnk_none) ? S_FIN : S_MRD;
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_ok     = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ok     <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
            r_full  <= n_full;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind <= i_kind;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

### rtl/coalesced_hash_set.sv
`default_nettype none
// channel   dir  tdata                                  tuser
// s_axis    in   elem[31:0]                             kind[1:0]
// m_axis    out  ok[0] full_res[1] count[6:2] pad[7]    -
//
// one operation at a time: the element is first reduced to its home slot, four bits per step,
// then each chain slot visited takes a registered slot memory read and a check,
// the free pointer takes a step for each slot it advances over, a remove pulls
// elements back with a read and a check for each slot scanned, and setup and
// result add their own steps
// reset is synchronous, active low; the table comes up empty with no clearing pass
// a finished result sits in the output register while the next transfer is taken;
// the next result is held back from it only if the previous one has not been taken yet
module coalesced_hash_set #(
    parameter int CAPACITY = chs_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // elem[31:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // ok, full_res, count[4:0], zero pad
);
    import chs_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic               res_ok, res_full;
    logic [COUNT_W-1:0] res_count;

    // sequencer: walks chains, moves elements on remove, steps the free pointer
    chs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // slot memories, occupancy bits, home reduction and result register
    chs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_ok    (res_ok),
        .o_full  (res_full),
        .o_count (res_count)
    );

    assign m_axis_tdata = {1'b0, res_count, res_full, res_ok};

endmodule
`default_nettype wire

### rtl/chs_checker.sv
`default_nettype none
`include "assert_macros.svh"
module chs_checker #(
    parameter int CAPACITY = chs_pkg::CAPACITY_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    // a pending result stays offered
    `CHS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // refused add never reports success
    `CHS_ASSERT_IMP(a_full_not_ok, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
    // element count bounded by the table size
    `CHS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, m_axis_tvalid, int'(m_axis_tdata[6:2]) <= CAPACITY)
    // nothing offered right after reset
    `CHS_ASSERT_IMP(a_rst_quiet, i_clk, i_rst_n, !$past(i_rst_n), !m_axis_tvalid)
endmodule

bind coalesced_hash_set chs_checker #(.CAPACITY(CAPACITY)) u_chk (.*);
`default_nettype wire
